// File: hdl/fse_pkg.sv
// Package for the flash slot EEPROM emulator: default sizes, codes and the
// controller state type. No dependencies.
`default_nettype none
package fse_pkg;
    localparam int SLOT_BYTES_DEF = 256;
    localparam int SLOT_COUNT_DEF = 8;
    localparam logic [7:0] BYTE_ERASED = 8'hFF;
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_COPY,
        S_APPLY,
        S_COMMIT,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// File: hdl/fse_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module fse_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/flash_slot_eeprom_emulator.sv
// Top level of the flash slot EEPROM emulator: controller, slot flags,
// flash store and staging RAM. Depends on fse_pkg and fse_ram.
//
// Usage: one input transaction (mode, byte_address, write_byte, last_byte)
// gives exactly one result transaction (read_byte, status, empty_slot,
// page_full). Both channels are valid/ready.
// An out-of-range read goes straight to the result; a read issues the flash
// read, then takes its data; a write byte in an open call goes to staging
// RAM; the first byte of a call first copies the image there, the last byte
// of a good call commits it to flash. Both copies move one byte per cycle
// through the single read port of the source RAM, which sets the rate.
// One item is worked on at a time; a new item is accepted as soon as the
// previous result sits in the output register.
// Reset: all slots read as erased (per-slot fill flags cleared), no call
// open; no clearing pass is needed. A full-page erase clears the flags at
// once.
// Receiver stall: the result waits in the output register; the next item
// is processed and then holds until the register frees.
`default_nettype none
module flash_slot_eeprom_emulator #(
    parameter int SLOT_BYTES = fse_pkg::SLOT_BYTES_DEF,
    parameter int SLOT_COUNT = fse_pkg::SLOT_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [15:0] i_byte_address,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_read_byte,
    output logic             o_status,
    output logic [2:0]       o_empty_slot,
    output logic             o_page_full
);
    import fse_pkg::*;

    localparam int AW  = $clog2(SLOT_BYTES);
    localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int EW  = $clog2(SLOT_COUNT + 1);
    localparam int FD  = SLOT_BYTES * SLOT_COUNT;
    localparam int FAW = $clog2(FD);
    localparam int CW  = $clog2(SLOT_BYTES + 1);

    t_state r_state, n_state;

    logic [SLOT_COUNT-1:0] r_slot_v;
    logic                  r_mode, r_last, r_bad, r_full, r_any;
    logic [15:0]           r_addr;
    logic [7:0]            r_wbyte, r_rbyte;
    logic [EW-1:0]         r_empty;
    logic                  r_call_open, r_call_bad;
    logic [CW-1:0]         r_cnt;
    logic                  r_wv;
    logic [AW-1:0]         r_wa;
    logic                  r_out_valid;

    logic [EW-1:0]  first_empty;
    logic           in_bad, accept, sweep, sweep_done, img_ok, out_free;
    logic [SW-1:0]  img_slot, tgt_slot;
    logic [FAW-1:0] img_base, tgt_base;
    logic           fl_we, st_we;
    logic [FAW-1:0] fl_waddr, fl_raddr;
    logic [AW-1:0]  st_waddr, st_raddr;
    logic [7:0]     fl_rdata, st_rdata, st_wdata, img_byte;

    always_comb begin
        first_empty = EW'(SLOT_COUNT);
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!r_slot_v[s]) begin
                first_empty = EW'(s);
            end
        end
    end

    assign in_bad     = i_byte_address >= 16'(SLOT_BYTES);
    assign o_ready    = (r_state == S_IDLE);
    assign accept     = i_valid && o_ready;
    assign out_free   = !r_out_valid || i_ready;
    assign sweep      = (r_state == S_COPY) || (r_state == S_COMMIT);
    assign sweep_done = (r_cnt == CW'(SLOT_BYTES)) && !r_wv;
    assign img_ok     = (r_empty != '0);
    assign img_slot   = r_full ? SW'(SLOT_COUNT - 1) : SW'(r_empty - EW'(1));
    assign tgt_slot   = r_full ? '0 : SW'(r_empty);
    assign img_base   = FAW'(img_slot) * FAW'(SLOT_BYTES);
    assign tgt_base   = FAW'(tgt_slot) * FAW'(SLOT_BYTES);
    assign img_byte   = img_ok ? fl_rdata : BYTE_ERASED;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_READ) begin
                        n_state = in_bad ? S_DONE : S_RD_ISSUE;
                    end else begin
                        n_state = r_call_open ? S_APPLY : S_COPY;
                    end
                end
            end
            S_RD_ISSUE: n_state = S_RD_DATA;
            S_RD_DATA:  n_state = S_DONE;
            S_COPY: begin
                if (sweep_done) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (r_last && !(r_call_bad || r_bad)) n_state = S_COMMIT;
                else n_state = S_DONE;
            end
            S_COMMIT: begin
                if (sweep_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        fl_we    = 1'b0;
        st_we    = 1'b0;
        fl_waddr = tgt_base + FAW'(r_wa);
        fl_raddr = img_base + FAW'(r_cnt[AW-1:0]);
        st_raddr = r_cnt[AW-1:0];
        st_waddr = r_wa;
        st_wdata = img_byte;
        unique case (r_state)
            S_RD_ISSUE: fl_raddr = img_base + FAW'(r_addr[AW-1:0]);
            S_COPY:     st_we = r_wv;
            S_APPLY: begin
                st_we    = !r_bad;
                st_waddr = r_addr[AW-1:0];
                st_wdata = r_wbyte;
            end
            S_COMMIT:   fl_we = r_wv;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot_v    <= '0;
            r_call_open <= 1'b0;
            r_call_bad  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) r_out_valid <= 1'b1;
            else if (o_valid && i_ready) r_out_valid <= 1'b0;
            r_wv <= sweep && (r_cnt != CW'(SLOT_BYTES));
            unique case (r_state)
                S_COPY: begin
                    if (sweep_done) begin
                        r_call_open <= 1'b1;
                        r_call_bad  <= 1'b0;
                    end
                end
                S_APPLY: begin
                    if (r_last) begin
                        r_call_open <= 1'b0;
                        r_call_bad  <= 1'b0;
                    end else if (r_bad) begin
                        r_call_bad <= 1'b1;
                    end
                end
                S_COMMIT: begin
                    if (sweep_done) begin
                        if (r_full) r_slot_v <= {{(SLOT_COUNT-1){1'b0}}, r_any};
                        else if (r_any) r_slot_v[tgt_slot] <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa <= r_cnt[AW-1:0];
        if (sweep && (r_cnt != CW'(SLOT_BYTES))) r_cnt <= r_cnt + CW'(1);
        if (r_state == S_APPLY) r_cnt <= '0;
        if ((r_state == S_COMMIT) && r_wv && (st_rdata != BYTE_ERASED)) r_any <= 1'b1;
        if (r_state == S_RD_DATA) r_rbyte <= img_byte;
        if (accept) begin
            r_mode  <= i_mode;
            r_addr  <= i_byte_address;
            r_wbyte <= i_write_byte;
            r_last  <= i_last_byte;
            r_bad   <= in_bad;
            r_empty <= first_empty;
            r_full  <= (first_empty == EW'(SLOT_COUNT));
            r_rbyte <= '0;
            r_cnt   <= '0;
            r_any   <= 1'b0;
        end
        if ((r_state == S_DONE) && out_free) begin
            o_read_byte  <= r_rbyte;
            o_status     <= r_bad ? STATUS_BAD : STATUS_OK;
            o_empty_slot <= r_full ? 3'd0 : 3'(r_empty);
            o_page_full  <= r_full;
        end
    end

    assign o_valid = r_out_valid;

    fse_ram #(.DW(8), .DEPTH(FD), .AW(FAW)) u_flash (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (st_rdata),
        .i_raddr (fl_raddr),
        .o_rdata (fl_rdata)
    );

    fse_ram #(.DW(8), .DEPTH(SLOT_BYTES), .AW(AW)) u_stage (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // filled slots always form a prefix of the page
    a_slot_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, r_slot_v} + {{SLOT_COUNT{1'b0}}, 1'b1}))
        else $error("slot flags not a prefix");
    a_bad_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_call_bad |-> r_call_open)
        else $error("call marked bad while closed");
    a_commit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> (r_mode == MODE_WRITE) && r_last && !r_bad)
        else $error("commit without a good last write");
endmodule
`default_nettype wire

// File: bench/flash_slot_eeprom_emulator_checker.sv
// Checker for the flash slot EEPROM emulator: watches both channels, keeps a
// shadow of the flash page and the open write call, and compares each result.
// Depends on fse_pkg.
`timescale 1ns / 100ps
module flash_slot_eeprom_emulator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic        i_mode,
    input  logic [15:0] i_byte_address,
    input  logic [7:0]  i_write_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [7:0]  i_read_byte,
    input  logic        i_status,
    input  logic [2:0]  i_empty_slot,
    input  logic        i_page_full,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_commits,
    output int          o_erases
);
    import fse_pkg::*;

    localparam int NSLOT = SLOT_COUNT_DEF;
    localparam int NBYTE = SLOT_BYTES_DEF;

    typedef struct packed {
        logic [7:0] rbyte;
        logic       status;
        logic [2:0] slot;
        logic       full;
    } t_result;

    logic [7:0] page_mem [NSLOT*NBYTE];
    logic [7:0] staging [NBYTE];
    bit         call_open, call_bad;
    t_result    expected_results [$];

    function automatic int first_erased_slot();
        bit erased;
        for (int s = 0; s < NSLOT; s++) begin
            erased = 1;
            for (int b = 0; b < NBYTE; b++)
                if (page_mem[s*NBYTE+b] != BYTE_ERASED) erased = 0;
            if (erased) return s;
        end
        return NSLOT;
    endfunction

    function automatic logic [7:0] image_at(int slot, int addr);
        if (slot == 0) return BYTE_ERASED;
        if (slot >= NSLOT) return page_mem[(NSLOT-1)*NBYTE+addr];
        return page_mem[(slot-1)*NBYTE+addr];
    endfunction

    task automatic apply_transaction(logic mode, logic [15:0] addr, logic [7:0] wb,
                                     logic last);
        int      slot;
        int      tgt;
        bit      full, bad;
        t_result r;
        slot = first_erased_slot();
        full = slot >= NSLOT;
        bad  = addr >= NBYTE;
        r    = '0;
        if (mode == MODE_READ) begin
            if (!bad) r.rbyte = image_at(slot, addr);
        end else begin
            if (!call_open) begin
                for (int a = 0; a < NBYTE; a++) staging[a] = image_at(slot, a);
                call_open = 1;
                call_bad  = 0;
            end
            if (bad) call_bad = 1;
            else staging[addr] = wb;
            if (last) begin
                if (!call_bad) begin
                    tgt = slot;
                    if (full) begin
                        for (int i = 0; i < NSLOT*NBYTE; i++) page_mem[i] = BYTE_ERASED;
                        tgt = 0;
                        o_erases++;
                    end
                    for (int a = 0; a < NBYTE; a++) page_mem[tgt*NBYTE+a] = staging[a];
                    o_commits++;
                end
                call_open = 0;
                call_bad  = 0;
            end
        end
        r.status = bad ? STATUS_BAD : STATUS_OK;
        r.slot   = full ? 3'd0 : slot[2:0];
        r.full   = full;
        expected_results.push_back(r);
    endtask

    initial begin
        for (int i = 0; i < NSLOT*NBYTE; i++) page_mem[i] = BYTE_ERASED;
        for (int i = 0; i < NBYTE; i++) staging[i] = '0;
        o_errors = 0; o_results = 0; o_commits = 0; o_erases = 0;
        call_open = 0; call_bad = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (i_valid && i_in_ready)
                apply_transaction(i_mode, i_byte_address, i_write_byte, i_last_byte);
            if (i_out_valid && i_ready) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result rb=%h st=%b slot=%0d full=%b",
                             $time, i_read_byte, i_status, i_empty_slot, i_page_full);
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.rbyte != i_read_byte) begin
                        $display("%0t: read_byte exp %h got %h", $time, e.rbyte, i_read_byte);
                        o_errors++;
                    end
                    if (e.status != i_status) begin
                        $display("%0t: status exp %b got %b", $time, e.status, i_status);
                        o_errors++;
                    end
                    if (e.slot != i_empty_slot) begin
                        $display("%0t: empty_slot exp %0d got %0d", $time, e.slot,
                                 i_empty_slot);
                        o_errors++;
                    end
                    if (e.full != i_page_full) begin
                        $display("%0t: page_full exp %b got %b", $time, e.full, i_page_full);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// File: bench/flash_slot_eeprom_emulator_tb.sv
// Testbench top for the flash slot EEPROM emulator: drives reads and write
// calls with random gaps and stalls, gives the verdict from the checker.
// Depends on fse_pkg, flash_slot_eeprom_emulator and its checker.
`timescale 1ns / 100ps
module flash_slot_eeprom_emulator_tb;
    import fse_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic        i_mode = MODE_READ;
    logic [15:0] i_byte_address = '0;
    logic [7:0]  i_write_byte = '0;
    logic        i_last_byte = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [7:0]  o_read_byte;
    logic        o_status;
    logic [2:0]  o_empty_slot;
    logic        o_page_full;
    int          errors, pending, results, commits, erases;
    int          idle_cycles = 0;
    int          sent = 0;
    bit          hold_off = 0;
    bit          timed_out = 0;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    flash_slot_eeprom_emulator dut (.*);

    flash_slot_eeprom_emulator_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_mode, .i_byte_address,
        .i_write_byte, .i_last_byte, .i_out_valid(o_valid), .i_ready, .i_read_byte(o_read_byte),
        .i_status(o_status), .i_empty_slot(o_empty_slot), .i_page_full(o_page_full),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_commits(commits), .o_erases(erases)
    );

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("%0t: watchdog expired", $time);
            $display("[flash_slot_eeprom_emulator] ERROR");
            $finish;
        end
    end

    // receiver: stall pattern, plus a long hold-off while hold_off is set
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) i_ready <= 0;
            else begin
                phase = (phase + 1) % 64;
                if (phase < 20) i_ready <= 1;
                else if (phase < 40) i_ready <= ($urandom_range(0, 3) != 0);
                else i_ready <= ($urandom_range(0, 1) != 0);
            end
        end
    end

    task automatic send_item(logic mode, logic [15:0] addr, logic [7:0] wb, logic last);
        i_valid        <= 1;
        i_mode         <= mode;
        i_byte_address <= addr;
        i_write_byte   <= wb;
        i_last_byte    <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_addr();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 16'($urandom_range(256, 65535));
        if (k == 1) return 16'hFFFF;
        if (k < 6) return 16'($urandom_range(0, 7));
        return 16'($urandom_range(0, 255));
    endfunction

    task automatic write_call(int len, bit allow_bad);
        logic [15:0] a;
        for (int i = 0; i < len; i++) begin
            a = allow_bad ? rand_addr() : 16'($urandom_range(0, 255));
            send_item(MODE_WRITE, a, 8'($urandom_range(0, 255)), i == len - 1);
            gap();
        end
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        send_item(MODE_READ, 16'd0, 8'h00, 0);
        send_item(MODE_READ, 16'd255, 8'h00, 0);
        send_item(MODE_READ, 16'd256, 8'h00, 0);
        send_item(MODE_READ, 16'hFFFF, 8'hFF, 1);
        send_item(MODE_WRITE, 16'd0, 8'h00, 0);
        send_item(MODE_READ, 16'd0, 8'h00, 0);
        send_item(MODE_WRITE, 16'd255, 8'hFF, 0);
        send_item(MODE_WRITE, 16'd1, 8'hA5, 1);
        send_item(MODE_READ, 16'd0, 8'h00, 0);
        send_item(MODE_READ, 16'd1, 8'h00, 0);
        send_item(MODE_WRITE, 16'd3, 8'h5A, 0);
        send_item(MODE_WRITE, 16'hFFFF, 8'h12, 0);
        send_item(MODE_WRITE, 16'd4, 8'h34, 1);
        send_item(MODE_WRITE, 16'd0, 8'hFF, 1);
        send_item(MODE_WRITE, 16'd1, 8'hFF, 1);
        send_item(MODE_WRITE, 16'd2, 8'h01, 1);
        send_item(MODE_WRITE, 16'd256, 8'h77, 1);
        send_item(MODE_READ, 16'd2, 8'h00, 0);

        drain();
        repeat (600) @(posedge i_clk);

        // long receiver hold-off while items keep coming
        hold_off = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++)
                send_item(MODE_READ, rand_addr(), 8'($urandom_range(0, 255)), 0);
        join
        drain();

        while (sent < 1400) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                send_item(MODE_READ, rand_addr(), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
                gap();
            end else if (r < 9) begin
                write_call($urandom_range(1, 6), $urandom_range(0, 7) == 0);
            end else begin
                i_valid <= 0;
                repeat ($urandom_range(5, 40)) @(posedge i_clk);
            end
        end

        drain();
        repeat (1000) @(posedge i_clk);
        $display("Sent %0d transactions, checked %0d results; %0d commits, %0d page erases.",
                 sent, results, commits, erases);
        if (errors == 0 && pending == 0)
            $display("[flash_slot_eeprom_emulator] OK");
        else
            $display("[flash_slot_eeprom_emulator] ERROR");
        $finish;
    end
endmodule
